>>> hdl/flowlet_gap_pfc_pause_generator_assert.svh
// Assertion macros for the pause generator.
`ifndef FLOWLET_GAP_PFC_PAUSE_GENERATOR_ASSERT_SVH
`define FLOWLET_GAP_PFC_PAUSE_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FGPG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fgpg check failed");
`define FGPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fgpg check failed");
`else
`define FGPG_ASSERT_SAME(label, clk, rst, ante, cons)
`define FGPG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/fgpg_pkg.sv
`default_nettype none
package fgpg_pkg;

   localparam int unsigned PRIORITY_COUNT   = 8;
   localparam int unsigned PRIO_W           = 3;
   localparam int unsigned PAD_BYTES_DEFAULT = 16;
   localparam int unsigned HDR_BYTES        = 14 + 4 + 2 * PRIORITY_COUNT;
   localparam int unsigned STAMP_W          = 48;
   localparam int unsigned QUANTA_W         = 16;
   localparam int unsigned CNT_W            = 6;
   localparam int unsigned POS_W            = 6;
   localparam int unsigned CSR_INDEX_W      = 3;

   localparam logic [2:0] CSR_GAP_MINIMUM   = 3'd0;
   localparam logic [2:0] CSR_FLOWLET_TMO   = 3'd1;
   localparam logic [2:0] CSR_QUANTA_DUR    = 3'd2;
   localparam logic [2:0] CSR_OWN_MAC       = 3'd3;
   localparam logic [2:0] CSR_PAUSE_DEST    = 3'd4;
   localparam logic [2:0] CSR_PRIO_MODE     = 3'd5;

   localparam logic [5:0] POS_STAMP_FIRST   = 6'd6;
   localparam logic [5:0] POS_STAMP_LAST    = 6'd11;
   localparam logic [5:0] POS_SERVICE       = 6'd15;
   localparam logic [5:0] POS_PROTOCOL      = 6'd23;
   localparam logic [5:0] POS_PORT_HIGH     = 6'd34;
   localparam logic [5:0] POS_CHECK         = 6'd35;
   localparam logic [5:0] POS_SAT           = 6'd36;

   localparam logic [5:0] OFS_SRC_MAC       = 6'd6;
   localparam logic [5:0] OFS_TYPE          = 6'd12;
   localparam logic [5:0] OFS_OPCODE        = 6'd14;
   localparam logic [5:0] OFS_PEV           = 6'd16;
   localparam logic [5:0] OFS_QUANTA        = 6'd18;
   localparam logic [5:0] OFS_QUANTA_LAST   = 6'd33;

   localparam logic [15:0] ROCE_PORT        = 16'd4791;
   localparam logic [7:0]  TCP_PROTO        = 8'd6;
   localparam logic [15:0] CTRL_TYPE        = 16'h8808;
   localparam logic [15:0] PFC_OPCODE       = 16'h0101;
   localparam logic [15:0] ALL_PRIO         = 16'h00ff;
   localparam logic [47:0] DEST_MAC_RESET   = 48'he8ebd358a02c;
   localparam logic [47:0] TIMEOUT_RESET    = 48'd65534;

endpackage
`default_nettype wire

>>> hdl/fgpg_divider.sv
`default_nettype none
module fgpg_divider import fgpg_pkg::*; #(
   parameter int unsigned WIDTH = QUANTA_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   input  wire logic [WIDTH-1:0] divisor,
   output logic                  done,
   output logic [WIDTH-1:0]      quotient
);

   localparam int unsigned STEP_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic               busy_ff, busy_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [WIDTH-1:0]   rem_ff, rem_in;
   logic [WIDTH-1:0]   quo_ff, quo_in;
   logic               done_ff, done_in;
   logic [WIDTH:0]     trial;
   logic [WIDTH:0]     diff;
   logic               fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[WIDTH-1]};
      diff    = trial - {1'b0, divisor};
      fits    = trial >= {1'b0, divisor};
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
         quo_in  = {quo_ff[WIDTH-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

>>> hdl/flowlet_gap_pfc_pause_generator.sv
`default_nettype none
// Flowlet gap PFC pause generator.
// req_* carries received Ethernet/IPv4 frame bytes, one byte per transfer, tlast on the
// final byte. rsp_* carries generated PFC pause frames, one byte per transfer, tlast on
// the final byte (34 + PAD_BYTES bytes). csr_* writes the six configuration registers
// by index and is always ready; the user must use it only while the block is idle, as
// the block does not enforce this. Bytes are taken one per cycle while the block is idle.
// When the byte at offset 35 closes a non-TCP header with source port 4791, the source
// MAC stamp is checked against the stored stamp by a bit-serial subtract and compare,
// during which req_tready stays low. If the delta lies within [gap minimum, flow idle
// limit], a 16-step bit-serial divide forms the quanta and the pause frame follows, one
// byte per cycle while rsp_tready allows, so input stays stalled until the last pause
// byte is issued. All other bytes are taken without stalling the input.
// rsp has one output register; a stall on rsp_tready holds the byte and stops frame
// generation, which holds the input side in turn.
// Reset (synchronous, active high) restores the register defaults, clears the stored
// stamp and captured header fields, and returns the byte offset to zero.
`include "flowlet_gap_pfc_pause_generator_assert.svh"
module flowlet_gap_pfc_pause_generator import fgpg_pkg::*; #(
   parameter int unsigned PAD_BYTES = PAD_BYTES_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // rx_byte[7:0]
   input  wire logic                   req_tlast,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [7:0]                  rsp_tdata,   // tx_byte[7:0]
   output logic                        rsp_tlast,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [STAMP_W-1:0]     csr_wdata
);

   localparam int unsigned FRAME_LEN = HDR_BYTES + PAD_BYTES;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DIFF = 4'b0010,
      S_DIV  = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   logic [STAMP_W-1:0]  gap_minimum_ff;
   logic [STAMP_W-1:0]  flow_idle_limit_ff;
   logic [QUANTA_W-1:0] quanta_duration_ff;
   logic [STAMP_W-1:0]  own_mac_ff;
   logic [STAMP_W-1:0]  pause_dest_mac_ff;
   logic                per_priority_mode_ff;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [STAMP_W-1:0]  stamp_ff, stamp_in;
   logic [STAMP_W-1:0]  prev_ff, prev_in;
   logic [7:0]          service_ff, service_in;
   logic [7:0]          protocol_ff, protocol_in;
   logic [7:0]          port_high_ff, port_high_in;
   logic                borrow_ff, borrow_in;
   logic                lt_ff, lt_in;
   logic                gt_ff, gt_in;
   logic [1:0]          carry_ff, carry_in;
   logic [QUANTA_W-1:0] stop_ff, stop_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                accept;
   logic                div_start;
   logic                div_done;
   logic [QUANTA_W-1:0] quanta;
   logic                bit_c, bit_p, bit_d, bit_g, bit_t;
   logic [2:0]          stop_sum;
   logic [PRIO_W-1:0]   prio;
   logic [15:0]         pev;
   logic [CNT_W-1:0]    q_off;
   logic                q_en;
   logic [7:0]          tx_byte;
   logic                out_free;

   function automatic logic [7:0] mac_byte(input logic [STAMP_W-1:0] mac,
                                           input logic [2:0] sel);
      return mac[{sel, 3'b000} +: 8];
   endfunction

   fgpg_divider #(
      .WIDTH (QUANTA_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (stop_ff),
      .divisor  (quanta_duration_ff),
      .done     (div_done),
      .quotient (quanta)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign prio = service_ff[7:5];
   assign pev  = per_priority_mode_ff ? (16'd1 << prio) : ALL_PRIO;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_minimum_ff       <= '0;
         flow_idle_limit_ff   <= TIMEOUT_RESET;
         quanta_duration_ff   <= QUANTA_W'(1);
         own_mac_ff           <= '0;
         pause_dest_mac_ff    <= DEST_MAC_RESET;
         per_priority_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GAP_MINIMUM: gap_minimum_ff       <= csr_wdata;
            CSR_FLOWLET_TMO: flow_idle_limit_ff   <= csr_wdata;
            CSR_QUANTA_DUR:  quanta_duration_ff   <= csr_wdata[QUANTA_W-1:0];
            CSR_OWN_MAC:     own_mac_ff           <= csr_wdata;
            CSR_PAUSE_DEST:  pause_dest_mac_ff    <= csr_wdata;
            CSR_PRIO_MODE:   per_priority_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // serial subtract and compare, LSB first
   always_comb begin
      bit_c    = stamp_ff[0];
      bit_p    = prev_ff[0];
      bit_d    = bit_c ^ bit_p ^ borrow_ff;
      bit_g    = gap_minimum_ff[cnt_ff];
      bit_t    = flow_idle_limit_ff[cnt_ff];
      stop_sum = {2'b00, bit_t} + {2'b00, ~bit_d} + {1'b0, carry_ff};
   end

   always_comb begin
      q_off   = cnt_ff - OFS_QUANTA;
      q_en    = !per_priority_mode_ff || (q_off[PRIO_W:1] == prio);
      case (cnt_ff) inside
         [6'd0 : 6'd5]:                 tx_byte = mac_byte(pause_dest_mac_ff,
                                                           3'(6'd5 - cnt_ff));
         [OFS_SRC_MAC : 6'd11]:         tx_byte = mac_byte(own_mac_ff, 3'(6'd11 - cnt_ff));
         OFS_TYPE:                      tx_byte = CTRL_TYPE[15:8];
         OFS_TYPE + 6'd1:               tx_byte = CTRL_TYPE[7:0];
         OFS_OPCODE:                    tx_byte = PFC_OPCODE[15:8];
         OFS_OPCODE + 6'd1:             tx_byte = PFC_OPCODE[7:0];
         OFS_PEV:                       tx_byte = pev[15:8];
         OFS_PEV + 6'd1:                tx_byte = pev[7:0];
         [OFS_QUANTA : OFS_QUANTA_LAST]: tx_byte = !q_en ? 8'h00 :
                                                  (q_off[0] ? quanta[7:0] : quanta[15:8]);
         default:                       tx_byte = 8'h00;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      stamp_in     = stamp_ff;
      prev_in      = prev_ff;
      service_in   = service_ff;
      protocol_in  = protocol_ff;
      port_high_in = port_high_ff;
      borrow_in    = borrow_ff;
      lt_in        = lt_ff;
      gt_in        = gt_ff;
      carry_in     = carry_ff;
      stop_in      = stop_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (pos_ff >= POS_STAMP_FIRST && pos_ff <= POS_STAMP_LAST) begin
                  stamp_in = {stamp_ff[STAMP_W-9:0], req_tdata};
               end else if (pos_ff == POS_SERVICE) begin
                  service_in = req_tdata;
               end else if (pos_ff == POS_PROTOCOL) begin
                  protocol_in = req_tdata;
               end else if (pos_ff == POS_PORT_HIGH) begin
                  port_high_in = req_tdata;
               end else if (pos_ff == POS_CHECK) begin
                  if (protocol_ff != TCP_PROTO && {port_high_ff, req_tdata} == ROCE_PORT) begin
                     state_in  = S_DIFF;
                     cnt_in    = '0;
                     borrow_in = 1'b0;
                     lt_in     = 1'b0;
                     gt_in     = 1'b0;
                     carry_in  = 2'd2;
                  end
               end
               if (req_tlast) begin
                  pos_in = '0;
               end else if (pos_ff < POS_SAT) begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         S_DIFF: begin
            stamp_in  = {bit_c, stamp_ff[STAMP_W-1:1]};
            prev_in   = {bit_c, prev_ff[STAMP_W-1:1]};
            borrow_in = (!bit_c && bit_p) || (!(bit_c ^ bit_p) && borrow_ff);
            lt_in     = (!bit_d && bit_g) || (!(bit_d ^ bit_g) && lt_ff);
            gt_in     = (bit_d && !bit_t) || (!(bit_d ^ bit_t) && gt_ff);
            carry_in  = stop_sum[2:1];
            if (cnt_ff < CNT_W'(QUANTA_W)) begin
               stop_in = {stop_sum[0], stop_ff[QUANTA_W-1:1]};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STAMP_W - 1)) begin
               if (!borrow_in && !lt_in && !gt_in) begin
                  state_in  = S_DIV;
                  div_start = 1'b1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_EMIT;
               cnt_in   = '0;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = tx_byte;
               rsp_last_in  = (cnt_ff == CNT_W'(FRAME_LEN - 1));
               cnt_in       = cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(FRAME_LEN - 1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         stamp_ff     <= '0;
         prev_ff      <= '0;
         service_ff   <= '0;
         protocol_ff  <= '0;
         port_high_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         stamp_ff     <= stamp_in;
         prev_ff      <= prev_in;
         service_ff   <= service_in;
         protocol_ff  <= protocol_in;
         port_high_ff <= port_high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      borrow_ff   <= borrow_in;
      lt_ff       <= lt_in;
      gt_ff       <= gt_in;
      carry_ff    <= carry_in;
      stop_ff     <= stop_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   `FGPG_ASSERT_SAME(a_state_onehot, clock, reset, 1'b1, $onehot(state_ff))
   `FGPG_ASSERT_SAME(a_done_in_div, clock, reset, div_done, state_ff == S_DIV)
   `FGPG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && !rsp_tready,
                     rsp_valid_ff && $stable(rsp_data_ff) && $stable(rsp_last_ff))
   `FGPG_ASSERT_NEXT(a_diff_exit, clock, reset,
                     state_ff == S_DIFF && cnt_ff == CNT_W'(STAMP_W - 1),
                     state_ff == S_IDLE || state_ff == S_DIV)

endmodule
`default_nettype wire

>>> tb/tb_flowlet_gap_pfc_pause_generator.sv
`default_nettype none
module tb_flowlet_gap_pfc_pause_generator import fgpg_pkg::*; ;

   localparam logic [47:0] MAX48       = 48'hffff_ffff_ffff;
   localparam int          QUIET       = 150;
   localparam int          LONG_HOLD   = 400;
   localparam int          STALL_LIMIT = 3000;
   localparam int          RANDOM_BYTES = 36;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } transfer_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = '0;   // rx_byte[7:0]
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;        // tx_byte[7:0]
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [STAMP_W-1:0]     csr_wdata = '0;

   flowlet_gap_pfc_pause_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   transfer_type rx_backlog[$];
   transfer_type pause_bytes_due[$];

   // register mirror
   logic [47:0] gap_min_r;
   logic [47:0] flowlet_tmo_r;
   logic [15:0] quanta_dur_r;
   logic [47:0] own_mac_r;
   logic [47:0] dest_mac_r;
   logic        per_prio_r;

   // receive-side parser mirror
   logic [5:0]  pos_m;
   logic [47:0] stamp_m;
   logic [7:0]  service_m;
   logic [7:0]  proto_m;
   logic [7:0]  port_hi_m;
   logic [47:0] prev_stamp_m;

   logic [47:0] sent_stamp;
   logic        req_idling = 1'b0;
   logic        rsp_idling = 1'b0;
   int          req_gap_left = 0;
   int          rsp_hold_left = 0;
   int          long_holds_req = 0;
   int          long_holds_done = 0;
   int          stall_cycles = 0;
   int          errors = 0;
   int          rx_accepted = 0;
   int          tx_accepted = 0;
   int          pause_frames = 0;
   int          csr_writes = 0;
   int          settings_used = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [47:0] rand48();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[47:0];
   endfunction

   function automatic void owe_pause_byte(input logic [7:0] b);
      pause_bytes_due.push_back('{data: b, last: 1'b0});
   endfunction

   function automatic void follow_rx_byte(input logic [7:0] b, input logic last);
      logic [15:0] port;
      logic [63:0] delta;
      logic [15:0] stop;
      logic [15:0] quanta;
      logic [15:0] pev;
      logic [15:0] q;
      logic [2:0]  prio;
      if (pos_m >= POS_STAMP_FIRST && pos_m <= POS_STAMP_LAST) begin
         stamp_m = {stamp_m[39:0], b};
      end else if (pos_m == POS_SERVICE) begin
         service_m = b;
      end else if (pos_m == POS_PROTOCOL) begin
         proto_m = b;
      end else if (pos_m == POS_PORT_HIGH) begin
         port_hi_m = b;
      end else if (pos_m == POS_CHECK) begin
         port = {port_hi_m, b};
         if (proto_m != TCP_PROTO && port == ROCE_PORT) begin
            delta = {16'd0, stamp_m} - {16'd0, prev_stamp_m};
            prev_stamp_m = stamp_m;
            if (delta >= {16'd0, gap_min_r} && delta <= {16'd0, flowlet_tmo_r}) begin
               stop = 16'(64'd1 + {16'd0, flowlet_tmo_r} - delta);
               quanta = (quanta_dur_r == 16'd0) ? 16'hffff : stop / quanta_dur_r;
               prio = service_m[7:5];
               pev = per_prio_r ? (16'd1 << prio) : ALL_PRIO;
               for (int i = 5; i >= 0; i--) owe_pause_byte(dest_mac_r[8*i +: 8]);
               for (int i = 5; i >= 0; i--) owe_pause_byte(own_mac_r[8*i +: 8]);
               owe_pause_byte(CTRL_TYPE[15:8]);
               owe_pause_byte(CTRL_TYPE[7:0]);
               owe_pause_byte(PFC_OPCODE[15:8]);
               owe_pause_byte(PFC_OPCODE[7:0]);
               owe_pause_byte(pev[15:8]);
               owe_pause_byte(pev[7:0]);
               for (int i = 0; i < PRIORITY_COUNT; i++) begin
                  q = (!per_prio_r || i == prio) ? quanta : 16'd0;
                  owe_pause_byte(q[15:8]);
                  owe_pause_byte(q[7:0]);
               end
               for (int i = 0; i < PAD_BYTES_DEFAULT; i++) owe_pause_byte(8'd0);
               pause_bytes_due[pause_bytes_due.size() - 1].last = 1'b1;
            end
         end
      end
      if (last) begin
         pos_m = '0;
      end else if (pos_m < POS_SAT) begin
         pos_m = pos_m + 6'd1;
      end
   endfunction

   // sender
   always @(posedge clock) begin
      transfer_type nxt;
      logic         offer;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap_left = 0;
      end else if (!req_tvalid || req_tready) begin
         offer = 1'b0;
         if (req_gap_left > 0) begin
            req_gap_left--;
         end else if (rx_backlog.size() > 0) begin
            nxt = rx_backlog.pop_front();
            req_tdata <= nxt.data;
            req_tlast <= nxt.last;
            offer = 1'b1;
            if (req_idling && $urandom_range(0, 5) == 0) req_gap_left = $urandom_range(1, 15);
         end
         req_tvalid <= offer;
      end
   end

   // receiver
   always @(posedge clock) begin
      logic rdy;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold_left = 0;
      end else begin
         rdy = 1'b0;
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
         end else if (long_holds_done < long_holds_req) begin
            long_holds_done++;
            rsp_hold_left = LONG_HOLD - 1;
         end else if (rsp_idling && $urandom_range(0, 7) == 0) begin
            rsp_hold_left = $urandom_range(1, 15) - 1;
         end else begin
            rdy = 1'b1;
         end
         rsp_tready <= rdy;
      end
   end

   // monitor: predict on input transfers, check output transfers
   always @(posedge clock) begin
      transfer_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            rx_accepted++;
            follow_rx_byte(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            tx_accepted++;
            if (rsp_tlast) pause_frames++;
            if (pause_bytes_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected pause byte: expected none, actual %02h last %0b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want = pause_bytes_due.pop_front();
               if (rsp_tdata !== want.data) begin
                  errors++;
                  $display("%0t: tx_byte mismatch: expected %02h, actual %02h",
                           $time, want.data, rsp_tdata);
               end
               if (rsp_tlast !== want.last) begin
                  errors++;
                  $display("%0t: tx_last mismatch: expected %0b, actual %0b",
                           $time, want.last, rsp_tlast);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d pause bytes outstanding",
                     $time, STALL_LIMIT, pause_bytes_due.size());
            $display("tb_flowlet_gap_pfc_pause_generator: FAIL");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [47:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
      case (idx)
         CSR_GAP_MINIMUM: gap_min_r     = val;
         CSR_FLOWLET_TMO: flowlet_tmo_r = val;
         CSR_QUANTA_DUR:  quanta_dur_r  = val[15:0];
         CSR_OWN_MAC:     own_mac_r     = val;
         CSR_PAUSE_DEST:  dest_mac_r    = val;
         CSR_PRIO_MODE:   per_prio_r    = val[0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [47:0] gap, input logic [47:0] tmo,
                            input logic [47:0] dur, input logic [47:0] own,
                            input logic [47:0] dest, input logic [47:0] mode);
      write_reg(CSR_GAP_MINIMUM, gap);
      write_reg(CSR_FLOWLET_TMO, tmo);
      write_reg(CSR_QUANTA_DUR, dur);
      write_reg(CSR_OWN_MAC, own);
      write_reg(CSR_PAUSE_DEST, dest);
      write_reg(CSR_PRIO_MODE, mode);
      settings_used++;
      @(negedge clock);
   endtask

   // wait for the block to go idle, then let any in-flight stamp compare finish
   task automatic drain();
      do @(negedge clock);
      while (rx_backlog.size() != 0 || req_tvalid || pause_bytes_due.size() != 0);
      repeat (QUIET) @(negedge clock);
   endtask

   task automatic queue_frame(input logic [47:0] stamp, input logic [7:0] service,
                              input logic [7:0] protocol, input logic [15:0] port,
                              input int len);
      logic [7:0] b;
      for (int p = 0; p < len; p++) begin
         b = 8'($urandom);
         if (p >= int'(POS_STAMP_FIRST) && p <= int'(POS_STAMP_LAST))
            b = stamp[8*(int'(POS_STAMP_LAST) - p) +: 8];
         else if (p == int'(POS_SERVICE)) b = service;
         else if (p == int'(POS_PROTOCOL)) b = protocol;
         else if (p == int'(POS_PORT_HIGH)) b = port[15:8];
         else if (p == int'(POS_CHECK)) b = port[7:0];
         rx_backlog.push_back('{data: b, last: (p == len - 1)});
      end
      if (len > int'(POS_CHECK) && protocol != TCP_PROTO && port == ROCE_PORT)
         sent_stamp = stamp;
   endtask

   task automatic random_settings();
      logic [47:0] gap;
      logic [63:0] t64;
      gap = ($urandom_range(0, 3) == 0) ? rand48() : 48'($urandom_range(0, 5000));
      t64 = {16'd0, gap} + 64'($urandom_range(0, 100000));
      write_all(gap, (t64 > {16'd0, MAX48}) ? MAX48 : t64[47:0],
                48'($urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(1, 65535)),
                rand48(), rand48(), 48'($urandom_range(0, 1)));
   endtask

   // mostly well-formed RoCE frames with in-range deltas, the rest near misses and noise
   task automatic random_frames(input int budget);
      int          used;
      int          kind;
      int          len;
      logic [63:0] span;
      logic [63:0] d;
      logic [7:0]  proto;
      used = 0;
      while (used < budget) begin
         kind = $urandom_range(0, 9);
         len = $urandom_range(36, 44);
         proto = $urandom_range(0, 1) ? 8'd17 : 8'($urandom);
         if (proto == TCP_PROTO) proto = 8'd17;
         if (kind < 8) begin
            if (kind < 6 && flowlet_tmo_r >= gap_min_r) begin
               span = {16'd0, flowlet_tmo_r} - {16'd0, gap_min_r} + 64'd1;
               d = {16'd0, gap_min_r} + ({$urandom, $urandom} % span);
            end else if (kind == 6 && gap_min_r != 48'd0) begin
               d = {$urandom, $urandom} % {16'd0, gap_min_r};
            end else begin
               d = {16'd0, flowlet_tmo_r} + 64'd1 + 64'($urandom_range(0, 1000));
            end
            queue_frame(48'({16'd0, sent_stamp} + d), 8'($urandom), proto, ROCE_PORT, len);
         end else if (kind == 8) begin
            queue_frame(rand48(), 8'($urandom),
                        $urandom_range(0, 1) ? TCP_PROTO : proto,
                        $urandom_range(0, 1) ? ROCE_PORT : 16'($urandom), len);
         end else begin
            len = $urandom_range(1, 50);
            queue_frame(rand48(), 8'($urandom), 8'($urandom), 16'($urandom), len);
         end
         used += len;
      end
   endtask

   initial begin
      gap_min_r = '0;
      flowlet_tmo_r = TIMEOUT_RESET;
      quanta_dur_r = 16'd1;
      own_mac_r = '0;
      dest_mac_r = DEST_MAC_RESET;
      per_prio_r = 1'b0;
      pos_m = '0;
      stamp_m = '0;
      service_m = '0;
      proto_m = '0;
      port_hi_m = '0;
      prev_stamp_m = '0;
      sent_stamp = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings; receiver holds off while the sender keeps offering
      long_holds_req++;
      settings_used++;
      rsp_idling = 1'b1;
      queue_frame(48'd100, 8'hb8, 8'd17, ROCE_PORT, 36);
      queue_frame(48'd5000, 8'h00, TCP_PROTO, ROCE_PORT, 37);
      queue_frame(48'd5000, 8'h00, 8'd17, ROCE_PORT, 5);
      drain();

      // per-priority mode, zero divisor, widest window
      req_idling = 1'b1;
      write_all(48'd10, MAX48, 48'd0, MAX48, 48'd0, 48'd1);
      queue_frame(sent_stamp + 48'd10, 8'hff, 8'd17, ROCE_PORT, 36);
      drain();

      // gap above timeout: nothing may pause
      write_all(MAX48, 48'd0, 48'd65535, 48'h0102_0304_0506, DEST_MAC_RESET, 48'd0);
      queue_frame(sent_stamp + 48'd1, 8'h00, 8'd17, ROCE_PORT, 36);
      drain();

      // last part: no idling on either side
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      random_settings();
      random_frames(RANDOM_BYTES);
      drain();

      $display("covered %0d received bytes over %0d register settings (%0d writes)",
               rx_accepted, settings_used, csr_writes);
      $display("checked %0d pause frames, %0d bytes", pause_frames, tx_accepted);
      if (errors == 0) begin
         $display("tb_flowlet_gap_pfc_pause_generator: PASS");
      end else begin
         $display("tb_flowlet_gap_pfc_pause_generator: FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
